### hw/rtl/ffba_pkg.sv
`timescale 1ns / 1ps

package ffba_pkg;

   localparam int unsigned HEAP_WORDS_DEF = 4096;
   localparam int unsigned WORD_W         = 14;
   localparam int unsigned HANDLE_W       = 12;
   localparam int unsigned BYTES_W        = 20;
   localparam int unsigned OP_W           = 2;
   localparam int unsigned STATUS_W       = 2;
   localparam int unsigned MIN_BLOCK      = 4;
   localparam int unsigned TAG_WORDS      = 2;

   typedef enum logic [OP_W-1:0] {
      OP_INIT    = 2'd0,
      OP_ALLOC   = 2'd1,
      OP_RELEASE = 2'd2,
      OP_RSVD    = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_DONE    = 2'd0,
      ST_IGNORED = 2'd1,
      ST_FULL    = 2'd2,
      ST_BAD     = 2'd3
   } status_type;

   typedef struct packed {
      logic              en;
      logic              we;
      logic [WORD_W-1:0] wdata;
   } mem_cmd_type;

endpackage

### hw/rtl/first_fit_block_allocator_core.sv
// Initialize writes the boundary tags of the heap and of one free block spanning the rest.
// Allocate walks the free list first fit and splits the block it takes when the rest is large enough.
// Release rejects a bad handle, else coalesces with a free neighbour on either or both sides.
// One operation is in flight at a time; the next beat is taken once the result beat is registered.
// Reset clears the control state and the free list head; the heap is undefined until initialize.
`timescale 1ns / 1ps

module first_fit_block_allocator_core #(
   parameter int unsigned HEAP_WORDS = ffba_pkg::HEAP_WORDS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // request_bytes[19:0], handle[31:20]
   input  logic [1:0]  req_tuser,   // operation[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // granted_handle[11:0], zero[15:12]
   output logic [1:0]  rsp_tuser    // status[1:0]
);
   import ffba_pkg::*;

   localparam int unsigned AW = $clog2(HEAP_WORDS);

   mem_cmd_type         mem_cmd;
   logic [AW-1:0]       mem_addr;
   logic [WORD_W-1:0]   mem_rdata;
   logic [HANDLE_W-1:0] rsp_granted;

   ffba_heap_ram #(.HEAP_WORDS(HEAP_WORDS), .AW(AW)) u_ram (
      .clock (clock),
      .cmd   (mem_cmd),
      .addr  (mem_addr),
      .rdata (mem_rdata)
   );

   ffba_seq #(.HEAP_WORDS(HEAP_WORDS), .AW(AW)) u_seq (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_op      (req_tuser),
      .req_bytes   (req_tdata[19:0]),
      .req_handle  (req_tdata[31:20]),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_granted (rsp_granted),
      .rsp_status  (rsp_tuser),
      .mem_cmd     (mem_cmd),
      .mem_addr    (mem_addr),
      .mem_rdata   (mem_rdata)
   );

   assign rsp_tdata = {4'b0000, rsp_granted};

endmodule

### hw/rtl/ffba_heap_ram.sv
`timescale 1ns / 1ps

module ffba_heap_ram #(
   parameter int unsigned HEAP_WORDS = ffba_pkg::HEAP_WORDS_DEF,
   parameter int unsigned AW         = $clog2(ffba_pkg::HEAP_WORDS_DEF)
) (
   input  logic                      clock,
   input  ffba_pkg::mem_cmd_type     cmd,
   input  logic [AW-1:0]             addr,
   output logic [ffba_pkg::WORD_W-1:0] rdata
);
   import ffba_pkg::*;

   logic [WORD_W-1:0] mem [HEAP_WORDS];
   logic [WORD_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (cmd.en) begin
         if (cmd.we) begin
            mem[addr] <= cmd.wdata;
         end else begin
            rdata_ff <= mem[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

### hw/rtl/ffba_seq.sv
`timescale 1ns / 1ps

module ffba_seq #(
   parameter int unsigned HEAP_WORDS = ffba_pkg::HEAP_WORDS_DEF,
   parameter int unsigned AW         = $clog2(ffba_pkg::HEAP_WORDS_DEF)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [ffba_pkg::OP_W-1:0]     req_op,
   input  logic [ffba_pkg::BYTES_W-1:0]  req_bytes,
   input  logic [ffba_pkg::HANDLE_W-1:0] req_handle,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [ffba_pkg::HANDLE_W-1:0] rsp_granted,
   output logic [ffba_pkg::STATUS_W-1:0] rsp_status,
   output ffba_pkg::mem_cmd_type         mem_cmd,
   output logic [AW-1:0]                 mem_addr,
   input  logic [ffba_pkg::WORD_W-1:0]   mem_rdata
);
   import ffba_pkg::*;

   localparam int unsigned VW = ((AW > 19) ? AW : 19) + 4;
   localparam int unsigned NW = AW + 1;
   localparam logic signed [VW-1:0] NV   = VW'(HEAP_WORDS);
   localparam logic signed [VW-1:0] TAGV = VW'(TAG_WORDS);
   localparam logic signed [VW-1:0] MINV = VW'(MIN_BLOCK);
   localparam logic [NW-1:0]        NCNT = NW'(HEAP_WORDS);

   typedef enum logic [4:0] {
      S_IDLE, S_INIT, S_AL_CHK, S_AL_SZ, S_AL_NX, S_AL_TAKE,
      S_UL0, S_UL1, S_UL2, S_UL3, S_SF,
      S_RL0, S_RL1, S_RL2, S_RL3, S_RL4, S_RL5, S_RL6, S_RL7, S_RL8, S_RL9,
      S_DONE
   } state_type;

   state_type state_ff, ret_ff;
   logic [2:0]              step_ff;
   logic signed [VW-1:0]    p_ff, words_ff, sz_ff, idx_ff, li_ff, ri_ff, ui_ff;
   logic signed [VW-1:0]    pv_ff, nx_ff, fh_ff, sfi_ff, sfw_ff;
   logic [NW-1:0]           n_ff;
   logic                    rd_ok_ff;
   logic [HANDLE_W-1:0]     gr_ff, rsp_gr_ff;
   status_type              st_ff, rsp_st_ff;
   logic                    rsp_valid_ff;

   logic signed [VW-1:0]    rd_val, rd_abs, acc_a, acc_v, take_w, li_calc;
   logic                    acc_en, acc_we, split, rel_bad, accept;
   logic [BYTES_W:0]        bytes_up;
   logic signed [VW-1:0]    words_calc;

   assign rd_val  = rd_ok_ff ? VW'($signed(mem_rdata)) : '0;
   assign rd_abs  = rd_val[VW-1] ? -rd_val : rd_val;
   assign split   = (sz_ff - words_ff) >= MINV;
   assign take_w  = split ? words_ff : sz_ff;
   assign li_calc = idx_ff - rd_abs;
   assign rel_bad = (idx_ff < TAGV) || !rd_val[VW-1] || (rd_abs < MINV) ||
                    ((idx_ff + rd_abs) > (NV - TAGV));
   assign bytes_up   = (BYTES_W + 1)'(req_bytes) + (BYTES_W + 1)'(3);
   assign words_calc = VW'(bytes_up >> 2) + TAGV;
   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      acc_en = 1'b0;
      acc_we = 1'b0;
      acc_a  = '0;
      acc_v  = '0;
      unique case (state_ff)
         S_INIT: begin
            acc_en = 1'b1;
            acc_we = 1'b1;
            unique case (step_ff)
               3'd0: begin acc_a = '0;                acc_v = -TAGV; end
               3'd1: begin acc_a = VW'(1);            acc_v = -TAGV; end
               3'd2: begin acc_a = TAGV;              acc_v = NV - VW'(4); end
               3'd3: begin acc_a = NV - VW'(3);       acc_v = NV - VW'(4); end
               3'd4: begin acc_a = VW'(3);            acc_v = '0; end
               3'd5: begin acc_a = VW'(4);            acc_v = '0; end
               3'd6: begin acc_a = NV - TAGV;         acc_v = -TAGV; end
               default: begin acc_a = NV - VW'(1);    acc_v = -TAGV; end
            endcase
         end
         S_AL_CHK: begin
            acc_en = !((p_ff == '0) || (n_ff == NCNT));
            acc_a  = p_ff;
         end
         S_AL_SZ: begin
            acc_en = !(rd_abs >= words_ff);
            acc_a  = p_ff + VW'(1);
         end
         S_UL0: begin acc_en = 1'b1; acc_a = ui_ff + VW'(2); end
         S_UL1: begin acc_en = 1'b1; acc_a = ui_ff + VW'(1); end
         S_UL2: begin
            acc_en = (pv_ff != '0);
            acc_we = 1'b1;
            acc_a  = pv_ff + VW'(1);
            acc_v  = rd_val;
         end
         S_UL3: begin
            acc_en = (nx_ff != '0);
            acc_we = 1'b1;
            acc_a  = nx_ff + VW'(2);
            acc_v  = pv_ff;
         end
         S_AL_TAKE: begin
            acc_en = 1'b1;
            acc_we = 1'b1;
            acc_a  = (step_ff == 3'd0) ? p_ff : p_ff + take_w - VW'(1);
            acc_v  = -take_w;
         end
         S_SF: begin
            acc_en = 1'b1;
            acc_we = 1'b1;
            unique case (step_ff)
               3'd0: begin acc_a = sfi_ff;                    acc_v = sfw_ff; end
               3'd1: begin acc_a = sfi_ff + sfw_ff - VW'(1);  acc_v = sfw_ff; end
               3'd2: begin acc_a = sfi_ff + VW'(1);           acc_v = fh_ff; end
               3'd3: begin acc_a = sfi_ff + VW'(2);           acc_v = '0; end
               default: begin
                  acc_en = (fh_ff != '0);
                  acc_a  = fh_ff + VW'(2);
                  acc_v  = sfi_ff;
               end
            endcase
         end
         S_RL0: begin acc_en = 1'b1; acc_a = idx_ff; end
         S_RL1: begin acc_en = !rel_bad; acc_a = idx_ff - VW'(1); end
         S_RL2: begin acc_en = 1'b1; acc_a = li_calc; end
         S_RL4: begin acc_en = 1'b1; acc_a = li_ff; end
         S_RL6: begin acc_en = 1'b1; acc_a = ri_ff; end
         S_RL8: begin acc_en = 1'b1; acc_a = ri_ff; end
         default: begin
            acc_en = 1'b0;
         end
      endcase
   end

   assign mem_cmd.en    = acc_en && !acc_a[VW-1] && (acc_a < NV);
   assign mem_cmd.we    = acc_we;
   assign mem_cmd.wdata = acc_v[WORD_W-1:0];
   assign mem_addr      = acc_a[AW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ret_ff       <= S_DONE;
         step_ff      <= '0;
         fh_ff        <= '0;
         rsp_valid_ff <= 1'b0;
         rd_ok_ff     <= 1'b0;
      end else begin
         rd_ok_ff <= mem_cmd.en && !mem_cmd.we;
         if (rsp_valid_ff && rsp_tready && (state_ff != S_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  gr_ff <= '0;
                  st_ff <= ST_DONE;
                  unique case (op_type'(req_op))
                     OP_INIT: begin
                        fh_ff    <= '0;
                        step_ff  <= '0;
                        state_ff <= S_INIT;
                     end
                     OP_ALLOC: begin
                        if (req_bytes == '0) begin
                           st_ff    <= ST_IGNORED;
                           state_ff <= S_DONE;
                        end else begin
                           words_ff <= (words_calc < MINV) ? MINV : words_calc;
                           p_ff     <= fh_ff;
                           n_ff     <= '0;
                           state_ff <= S_AL_CHK;
                        end
                     end
                     OP_RELEASE: begin
                        if (req_handle == '0) begin
                           st_ff    <= ST_IGNORED;
                           state_ff <= S_DONE;
                        end else begin
                           idx_ff   <= VW'(req_handle) - VW'(1);
                           state_ff <= S_RL0;
                        end
                     end
                     default: begin
                        state_ff <= S_DONE;
                     end
                  endcase
               end
            end
            S_INIT: begin
               step_ff <= step_ff + 3'd1;
               if (step_ff == 3'd7) begin
                  fh_ff    <= TAGV;
                  state_ff <= S_DONE;
               end
            end
            S_AL_CHK: begin
               if ((p_ff == '0) || (n_ff == NCNT)) begin
                  st_ff    <= ST_FULL;
                  state_ff <= S_DONE;
               end else begin
                  state_ff <= S_AL_SZ;
               end
            end
            S_AL_SZ: begin
               sz_ff <= rd_abs;
               if (rd_abs >= words_ff) begin
                  ui_ff    <= p_ff;
                  ret_ff   <= S_AL_TAKE;
                  step_ff  <= '0;
                  state_ff <= S_UL0;
               end else begin
                  state_ff <= S_AL_NX;
               end
            end
            S_AL_NX: begin
               p_ff     <= rd_val;
               n_ff     <= n_ff + NW'(1);
               state_ff <= S_AL_CHK;
            end
            S_UL0: state_ff <= S_UL1;
            S_UL1: begin
               pv_ff    <= rd_val;
               state_ff <= S_UL2;
            end
            S_UL2: begin
               nx_ff <= rd_val;
               if (pv_ff == '0) begin
                  fh_ff <= rd_val;
               end
               state_ff <= S_UL3;
            end
            S_UL3: begin
               step_ff  <= '0;
               state_ff <= ret_ff;
            end
            S_AL_TAKE: begin
               if (step_ff == 3'd0) begin
                  step_ff <= 3'd1;
               end else begin
                  gr_ff   <= HANDLE_W'(p_ff + VW'(1));
                  step_ff <= '0;
                  if (split) begin
                     sfi_ff   <= p_ff + words_ff;
                     sfw_ff   <= sz_ff - words_ff;
                     ret_ff   <= S_DONE;
                     state_ff <= S_SF;
                  end else begin
                     state_ff <= S_DONE;
                  end
               end
            end
            S_SF: begin
               step_ff <= step_ff + 3'd1;
               if (step_ff == 3'd4) begin
                  fh_ff    <= sfi_ff;
                  state_ff <= ret_ff;
               end
            end
            S_RL0: state_ff <= S_RL1;
            S_RL1: begin
               sz_ff <= rd_abs;
               if (rel_bad) begin
                  st_ff    <= ST_BAD;
                  state_ff <= S_DONE;
               end else begin
                  state_ff <= S_RL2;
               end
            end
            S_RL2: begin
               li_ff    <= li_calc;
               ri_ff    <= idx_ff + sz_ff;
               state_ff <= S_RL3;
            end
            S_RL3: begin
               if (!rd_val[VW-1] && (rd_val != '0)) begin
                  ui_ff    <= li_ff;
                  ret_ff   <= S_RL4;
                  state_ff <= S_UL0;
               end else begin
                  state_ff <= S_RL6;
               end
            end
            S_RL4: state_ff <= S_RL5;
            S_RL5: begin
               sz_ff    <= sz_ff + rd_abs;
               idx_ff   <= li_ff;
               state_ff <= S_RL6;
            end
            S_RL6: state_ff <= S_RL7;
            S_RL7: begin
               if (!rd_val[VW-1] && (rd_val != '0)) begin
                  ui_ff    <= ri_ff;
                  ret_ff   <= S_RL8;
                  state_ff <= S_UL0;
               end else begin
                  sfi_ff   <= idx_ff;
                  sfw_ff   <= sz_ff;
                  ret_ff   <= S_DONE;
                  step_ff  <= '0;
                  state_ff <= S_SF;
               end
            end
            S_RL8: state_ff <= S_RL9;
            S_RL9: begin
               sfi_ff   <= idx_ff;
               sfw_ff   <= sz_ff + rd_abs;
               ret_ff   <= S_DONE;
               step_ff  <= '0;
               state_ff <= S_SF;
            end
            S_DONE: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_gr_ff    <= gr_ff;
                  rsp_st_ff    <= st_ff;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_tvalid  = rsp_valid_ff;
   assign rsp_granted = rsp_gr_ff;
   assign rsp_status  = rsp_st_ff;

endmodule

### hw/rtl/ffba_checker.sv
`timescale 1ns / 1ps

module ffba_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic [1:0]  rsp_tuser
);
   import ffba_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result beat changed while stalled");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second request taken while an operation is in progress");

   a_handle_only_on_success: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != ST_DONE) |-> rsp_tdata[11:0] == 12'd0)
      else $error("nonzero handle returned with a failure status");

   a_result_needs_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(!req_tready))
      else $error("result beat appeared without an operation in progress");

endmodule

bind first_fit_block_allocator_core ffba_checker u_ffba_checker (.*);

### dv/first_fit_block_allocator_core_tb.sv
`timescale 1ns / 1ps

module first_fit_block_allocator_core_tb;
   import ffba_pkg::*;

   localparam int HEAP = HEAP_WORDS_DEF;
   localparam longint CYCLE_LIMIT = 10000000;

   class heap_scoreboard;
      logic [WORD_W-1:0] words [HEAP];
      bit                known [HEAP];
      longint            head;
      bit                strayed;
      logic [HANDLE_W-1:0] grant_q [$];
      status_type          status_q [$];
      int                  mismatches;

      function new();
         foreach (known[i]) known[i] = 0;
         head = 0;
         mismatches = 0;
      endfunction

      function longint rd(longint i);
         if (i < 0 || i >= HEAP) return 0;
         if (!known[i]) strayed = 1;
         return longint'($signed(words[i]));
      endfunction

      function void wr(longint i, longint v);
         if (i < 0 || i >= HEAP) return;
         words[i] = v[WORD_W-1:0];
         known[i] = 1;
      endfunction

      function longint size_at(longint i);
         longint v;
         v = rd(i);
         return v < 0 ? -v : v;
      endfunction

      function void mark_taken(longint i, longint n);
         wr(i, -n);
         wr(i + n - 1, -n);
      endfunction

      function void push_free(longint i, longint n);
         wr(i, n);
         wr(i + n - 1, n);
         wr(i + 1, head);
         wr(i + 2, 0);
         if (head != 0) wr(head + 2, i);
         head = i;
      endfunction

      function void unlink(longint i);
         longint pv, nx;
         pv = rd(i + 2);
         nx = rd(i + 1);
         if (pv == 0) head = nx;
         else wr(pv + 1, nx);
         if (nx != 0) wr(nx + 2, pv);
      endfunction

      function void compute(op_type op, logic [BYTES_W-1:0] bytes, logic [HANDLE_W-1:0] h,
                            output logic [HANDLE_W-1:0] grant, output status_type st);
         longint need, p, sz, idx, li, ri, hv;
         int n;
         bit found;
         grant = '0;
         st = ST_DONE;
         case (op)
            OP_INIT: begin
               head = 0;
               mark_taken(0, TAG_WORDS);
               push_free(2, HEAP - 4);
               mark_taken(HEAP - 2, TAG_WORDS);
            end
            OP_ALLOC: begin
               if (bytes == 0) begin
                  st = ST_IGNORED;
               end else begin
                  need = (longint'(bytes) + 3) / 4 + TAG_WORDS;
                  if (need < MIN_BLOCK) need = MIN_BLOCK;
                  p = head;
                  found = 0;
                  for (n = 0; n < HEAP && p != 0 && !found; n++) begin
                     sz = size_at(p);
                     if (sz >= need) begin
                        unlink(p);
                        if (sz - need >= MIN_BLOCK) begin
                           mark_taken(p, need);
                           push_free(p + need, sz - need);
                        end else begin
                           mark_taken(p, sz);
                        end
                        grant = HANDLE_W'(p + 1);
                        found = 1;
                     end else begin
                        p = rd(p + 1);
                     end
                  end
                  if (!found) st = ST_FULL;
               end
            end
            OP_RELEASE: begin
               if (h == 0) begin
                  st = ST_IGNORED;
               end else begin
                  idx = longint'(h) - 1;
                  hv = rd(idx);
                  sz = hv < 0 ? -hv : hv;
                  if (idx < 2 || hv >= 0 || sz < MIN_BLOCK || idx + sz > HEAP - 2) begin
                     st = ST_BAD;
                  end else begin
                     li = idx - size_at(idx - 1);
                     ri = idx + sz;
                     if (rd(li) > 0) begin
                        unlink(li);
                        sz += size_at(li);
                        idx = li;
                     end
                     if (rd(ri) > 0) begin
                        unlink(ri);
                        sz += size_at(ri);
                     end
                     push_free(idx, sz);
                  end
               end
            end
            default: ;
         endcase
      endfunction

      // Runs the operation on a scratch copy and reports whether it reads
      // only heap words that have been written.
      function bit is_safe(op_type op, logic [BYTES_W-1:0] bytes, logic [HANDLE_W-1:0] h);
         logic [WORD_W-1:0] saved_words [HEAP];
         bit saved_known [HEAP];
         longint saved_head;
         logic [HANDLE_W-1:0] g;
         status_type st;
         saved_words = words;
         saved_known = known;
         saved_head = head;
         strayed = 0;
         compute(op, bytes, h, g, st);
         words = saved_words;
         known = saved_known;
         head = saved_head;
         return !strayed;
      endfunction

      function logic [HANDLE_W-1:0] note_request(op_type op, logic [BYTES_W-1:0] bytes,
                                                 logic [HANDLE_W-1:0] h);
         logic [HANDLE_W-1:0] g;
         status_type st;
         compute(op, bytes, h, g, st);
         grant_q.push_back(g);
         status_q.push_back(st);
         return g;
      endfunction

      function void check_result(logic [15:0] data, logic [1:0] user);
         logic [HANDLE_W-1:0] g;
         status_type st;
         if (grant_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("Unexpected result beat: handle %0d status %0d", data[11:0], user);
            return;
         end
         g = grant_q.pop_front();
         st = status_q.pop_front();
         if (data[11:0] !== g || data[15:12] !== 4'd0 || user !== st) begin
            mismatches++;
            if (mismatches <= 10)
               $display("Mismatch: expected handle %0d status %0d, got data %h status %0d",
                        g, st, data, user);
         end
      endfunction

      function int pending();
         return grant_q.size();
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [15:0] rsp_tdata;
   logic [1:0]  rsp_tuser;

   heap_scoreboard sb = new();
   int live [$];
   int burst_left = 3;
   int stall_mode = 0;
   longint cycles = 0;

   first_fit_block_allocator_core dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata, rsp_tuser);
      if (cycles % 97 == 0) stall_mode = $urandom_range(0, 2);
      case (stall_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= 1'($urandom_range(0, 1));
         default: rsp_tready <= ($urandom_range(0, 3) == 0);
      endcase
   end

   task automatic send_item(op_type op, logic [BYTES_W-1:0] bytes, logic [HANDLE_W-1:0] h);
      logic [HANDLE_W-1:0] g;
      int idx;
      if (!sb.is_safe(op, bytes, h)) return;
      req_tuser <= op;
      req_tdata <= {h, bytes};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      g = sb.note_request(op, bytes, h);
      if (op == OP_INIT) live.delete();
      if (op == OP_ALLOC && g != 0) live.push_back(int'(g));
      if (op == OP_RELEASE) begin
         for (idx = live.size() - 1; idx >= 0; idx--)
            if (live[idx] == int'(h)) live.delete(idx);
      end
      burst_left--;
      if (burst_left <= 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 20)) @(posedge clock);
         burst_left = $urandom_range(1, 12);
      end
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic random_item();
      int r;
      logic [BYTES_W-1:0] bytes;
      logic [HANDLE_W-1:0] h;
      r = $urandom_range(0, 99);
      bytes = BYTES_W'($urandom);
      h = HANDLE_W'($urandom);
      if (r < 2) begin
         send_item(OP_INIT, bytes, h);
      end else if (r < 5) begin
         send_item(OP_RSVD, bytes, h);
      end else if (r < 52 || live.size() == 0) begin
         r = $urandom_range(0, 99);
         if (r < 60) bytes = BYTES_W'($urandom_range(1, 64));
         else if (r < 85) bytes = BYTES_W'($urandom_range(1, 2000));
         else if (r < 92) bytes = BYTES_W'($urandom_range(1, 20000));
         else if (r < 97) bytes = BYTES_W'($urandom);
         else bytes = '0;
         send_item(OP_ALLOC, bytes, h);
      end else if (r < 88) begin
         send_item(OP_RELEASE, bytes, HANDLE_W'(live[$urandom_range(0, live.size() - 1)]));
      end else if (r < 96) begin
         send_item(OP_RELEASE, bytes, h);
      end else begin
         send_item(OP_RELEASE, bytes, '0);
      end
   endtask

   initial begin
      int a, b, c;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_item(OP_INIT, 20'hFFFFF, 12'hFFF);
      send_item(OP_RSVD, 20'hFFFFF, 12'hFFF);
      send_item(OP_ALLOC, '0, 12'hFFF);
      send_item(OP_ALLOC, 20'd1, '0);
      send_item(OP_ALLOC, 20'd12, '0);
      send_item(OP_ALLOC, 20'd16, '0);
      send_item(OP_ALLOC, 20'hFFFFF, '0);
      send_item(OP_RELEASE, '0, '0);
      send_item(OP_RELEASE, '0, 12'd1);
      send_item(OP_RELEASE, '0, 12'd2);
      send_item(OP_RELEASE, '0, 12'hFFF);
      a = live[0];
      b = live[1];
      c = live[2];
      send_item(OP_RELEASE, '0, HANDLE_W'(b));
      send_item(OP_RELEASE, '0, HANDLE_W'(a));
      send_item(OP_RELEASE, '0, HANDLE_W'(c));
      send_item(OP_RELEASE, '0, HANDLE_W'(c));
      send_item(OP_INIT, '0, '0);
      send_item(OP_ALLOC, 20'd16360, '0);
      send_item(OP_ALLOC, 20'd1, '0);
      send_item(OP_RELEASE, '0, HANDLE_W'(live[0]));
      send_item(OP_ALLOC, 20'd16361, '0);
      send_item(OP_ALLOC, 20'd16352, '0);
      send_item(OP_RELEASE, '0, HANDLE_W'(live[0]));
      drain();

      for (int k = 0; k < 850; k++) begin
         random_item();
         if (k == 400) drain();
      end
      drain();

      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
